@@ rtl/core/tnc_pkg.sv @@
// ----------------------------------------------------------------------------
// tnc_pkg - shared types and constants of the tag nesting checker
// Tag marks, fault codes, stack depth default and the stack shift command.
// ----------------------------------------------------------------------------
`default_nettype none

package tnc_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;

   localparam logic [7:0] OPEN_MARK  = 8'h3C;
   localparam logic [7:0] CLOSE_MARK = 8'h2F;

   typedef logic [2:0] fault_type;

   localparam fault_type FAULT_NONE     = 3'd0;
   localparam fault_type FAULT_MISMATCH = 3'd1;
   localparam fault_type FAULT_EMPTY    = 3'd2;
   localparam fault_type FAULT_OPEN     = 3'd3;
   localparam fault_type FAULT_OVERFLOW = 3'd4;

   // Shift command broadcast to every stack cell.
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } stack_op_type;

endpackage

`default_nettype wire

@@ rtl/core/tnc_cell.sv @@
// ----------------------------------------------------------------------------
// tnc_cell - one entry of the shifting tag stack
// Takes the entry above it on a push and the entry below it on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_cell
   import tnc_pkg::*;
(
   input  wire logic         clock,
   input  wire stack_op_type op,
   input  wire logic [7:0]   from_up,
   input  wire logic [7:0]   from_down,
   output logic [7:0]        value
);

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (op.push) begin
         value_in = from_up;
      end else if (op.pop) begin
         value_in = from_down;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

@@ rtl/core/tnc_judge.sv @@
// ----------------------------------------------------------------------------
// tnc_judge - evaluate one markup position
// Decodes a '<' position from its two lookahead bytes, issues the stack
// command and updates the tag count and the sticky fault code.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_judge
   import tnc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  wire logic          enable,
   input  wire logic [7:0]    c0,
   input  wire logic [7:0]    c1,
   input  wire logic [7:0]    c2,
   input  wire logic [7:0]    top,
   input  wire logic [CW-1:0] count,
   input  wire fault_type     fault,
   output stack_op_type       op,
   output logic [CW-1:0]      count_next,
   output fault_type          fault_next
);

   logic is_open;

   assign is_open = enable && (fault == FAULT_NONE) && (c0 == OPEN_MARK);

   always_comb begin
      op         = '{push: 1'b0, pop: 1'b0, data: c1};
      count_next = count;
      fault_next = fault;
      if (is_open) begin
         if (c1 == CLOSE_MARK) begin
            if (count == '0) begin
               fault_next = FAULT_EMPTY;
            end else begin
               // pop even on a mismatch, then flag it
               op.pop     = 1'b1;
               count_next = count - CW'(1);
               if (top != c2) begin
                  fault_next = FAULT_MISMATCH;
               end
            end
         end else begin
            if (count == CW'(STACK_DEPTH)) begin
               fault_next = FAULT_OVERFLOW;
            end else begin
               op.push    = 1'b1;
               count_next = count + CW'(1);
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tag_nesting_checker.sv @@
// ----------------------------------------------------------------------------
// tag_nesting_checker - single-character tag nesting check over one line
// Streams a line of markup byte by byte and reports whether its tags nest.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one byte per word (req_char_in), req_is_last on the final
//   byte of the line, newline excluded. Bytes are taken one per cycle while
//   req_ready is high. rsp_ channel: one word per line, rsp_line_valid and
//   rsp_fault_kind. Every '<' is judged two bytes late, once its lookahead
//   is in. The stack is a chain of cells shifting on push and pop. After the
//   last byte req_ready drops for a flush of one step per pending position
//   in the lookahead window, one or two; the verdict is registered at the
//   end of the flush, and the next line's bytes are taken only after that.
//   A waiting verdict does not stop the next line's bytes; only the flush of
//   a following line waits while rsp_valid is high and rsp_ready is low.
//   Reset clears the window, tag count, fault code and output valid flag; the
//   stack cells need no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_nesting_checker
   import tnc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_line_valid,
   output logic [2:0]       rsp_fault_kind
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type       state_ff, state_in;
   logic [7:0]      w0_ff, w0_in;
   logic [7:0]      w1_ff, w1_in;
   logic [1:0]      fill_ff, fill_in;
   logic [CW-1:0]   count_ff, count_in;
   fault_type       fault_ff, fault_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_line_valid_ff, rsp_line_valid_in;
   fault_type       rsp_fault_ff, rsp_fault_in;

   logic            accept;
   logic            flush_go;
   logic            verdict_load;
   logic            judge_en;
   logic [7:0]      judge_c2;
   stack_op_type    op;
   logic [CW-1:0]   count_judged;
   fault_type       fault_judged;
   fault_type       verdict;
   logic [7:0]      cell_q [STACK_DEPTH];

   assign req_ready    = (state_ff == ST_RUN);
   assign accept       = req_valid && req_ready;
   assign flush_go     = (state_ff == ST_FLUSH) && (!rsp_valid_ff || rsp_ready);
   assign verdict_load = flush_go && (fill_ff == 2'd1);
   assign judge_en     = flush_go || (accept && fill_ff == 2'd2);
   assign judge_c2     = (state_ff == ST_FLUSH) ? 8'h00 : req_char_in;

   tnc_judge #(.STACK_DEPTH(STACK_DEPTH)) u_judge (
      .enable     (judge_en),
      .c0         (w0_ff),
      .c1         (w1_ff),
      .c2         (judge_c2),
      .top        (cell_q[0]),
      .count      (count_ff),
      .fault      (fault_ff),
      .op         (op),
      .count_next (count_judged),
      .fault_next (fault_judged)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [7:0] up_val;
      logic [7:0] down_val;
      if (i == 0) begin : g_head
         assign up_val = op.data;
      end else begin : g_mid_up
         assign up_val = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign down_val = 8'h00;
      end else begin : g_mid_down
         assign down_val = cell_q[i+1];
      end
      tnc_cell u_cell (
         .clock     (clock),
         .op        (op),
         .from_up   (up_val),
         .from_down (down_val),
         .value     (cell_q[i])
      );
   end

   always_comb begin
      if (fault_judged != FAULT_NONE) begin
         verdict = fault_judged;
      end else if (count_judged != '0) begin
         verdict = FAULT_OPEN;
      end else begin
         verdict = FAULT_NONE;
      end
   end

   always_comb begin
      state_in          = state_ff;
      w0_in             = w0_ff;
      w1_in             = w1_ff;
      fill_in           = fill_ff;
      count_in          = count_judged;
      fault_in          = fault_judged;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_line_valid_in = rsp_line_valid_ff;
      rsp_fault_in      = rsp_fault_ff;

      if (accept) begin
         case (fill_ff)
            2'd0: begin
               w0_in   = req_char_in;
               fill_in = 2'd1;
            end
            2'd1: begin
               w1_in   = req_char_in;
               fill_in = 2'd2;
            end
            default: begin
               w0_in = w1_ff;
               w1_in = req_char_in;
            end
         endcase
         if (req_is_last) begin
            state_in = ST_FLUSH;
         end
      end

      if (flush_go) begin
         // advance the window with zero lookahead
         w0_in   = w1_ff;
         w1_in   = 8'h00;
         fill_in = fill_ff - 2'd1;
      end

      if (verdict_load) begin
         rsp_valid_in      = 1'b1;
         rsp_line_valid_in = (verdict == FAULT_NONE);
         rsp_fault_in      = verdict;
         // drop the line state for the next line
         state_in          = ST_RUN;
         w0_in             = 8'h00;
         w1_in             = 8'h00;
         fill_in           = 2'd0;
         count_in          = '0;
         fault_in          = FAULT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         w0_ff        <= 8'h00;
         w1_ff        <= 8'h00;
         fill_ff      <= 2'd0;
         count_ff     <= '0;
         fault_ff     <= FAULT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w0_ff        <= w0_in;
         w1_ff        <= w1_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_line_valid_ff <= rsp_line_valid_in;
      rsp_fault_ff      <= rsp_fault_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_valid = rsp_line_valid_ff;
   assign rsp_fault_kind = rsp_fault_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("tag count beyond stack depth");

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != FAULT_NONE && !verdict_load) |=> fault_ff == $past(fault_ff))
      else $error("fault code changed within a line");

   a_flush_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (fill_ff == 2'd1 || fill_ff == 2'd2))
      else $error("flush with empty window");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      !(op.push && op.pop))
      else $error("push and pop in the same cycle");

   a_verdict_slot: assert property (@(posedge clock) disable iff (reset)
      verdict_load |=> rsp_valid_ff && rsp_line_valid_ff == (rsp_fault_ff == FAULT_NONE))
      else $error("verdict not registered");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the tag nesting checker
// Streams lines of markup into the block under random valid/ready gaps and
// compares every verdict with the table's or with a shadow of the tag stack
// kept in the bench. A short table of directed lines comes first, then
// random lines: half well-nested, a quarter broken on purpose, a quarter plain noise.
// ----------------------------------------------------------------------------

module tb_top
   import tnc_pkg::*;
();

   localparam int TAG_DEPTH   = DEFAULT_STACK_DEPTH;
   localparam int BYTE_TARGET = 1400;
   localparam int LINE_TARGET = 60;
   localparam int HOLD_AT     = 1000;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic      ok;
      fault_type kind;
   } verdict_type;

   typedef struct {
      logic [7:0]  ch;
      bit          last;
      bit          typed;
      verdict_type want;
   } row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_in;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_line_valid;
   logic [2:0] rsp_fault_kind;

   tag_nesting_checker #(
      .STACK_DEPTH(TAG_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_valid (rsp_line_valid),
      .rsp_fault_kind (rsp_fault_kind)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // shadow of the line state
   logic [7:0] shadow_stack [TAG_DEPTH];
   int         shadow_depth = 0;
   logic [7:0] shadow_win [2];
   int         shadow_fill = 0;
   fault_type  shadow_fault = FAULT_NONE;

   verdict_type verdict_q [$];
   row_type     script [$];
   logic [7:0]  line_buf [$];

   int fail_count    = 0;
   int bytes_sent    = 0;
   int lines_done    = 0;
   int verdicts_seen = 0;
   int kind_seen [5] = '{0, 0, 0, 0, 0};
   int tx_idle_pct   = 36;
   int rx_idle_pct   = 72;
   int idle_cycles   = 0;

   task automatic report_fault(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void judge_tag(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [7:0] c2);
      if (shadow_fault != FAULT_NONE || c0 != OPEN_MARK)
         return;
      if (c1 == CLOSE_MARK) begin
         if (shadow_depth == 0) begin
            shadow_fault = FAULT_EMPTY;
            return;
         end
         shadow_depth--;
         if (shadow_stack[shadow_depth] != c2)
            shadow_fault = FAULT_MISMATCH;
      end else begin
         if (shadow_depth >= TAG_DEPTH) begin
            shadow_fault = FAULT_OVERFLOW;
            return;
         end
         shadow_stack[shadow_depth] = c1;
         shadow_depth++;
      end
   endfunction

   // Advance the shadow by one byte; returns 1 when the byte closes a line.
   function automatic bit line_verdict(input logic [7:0] b, input bit last,
                                       output verdict_type v);
      fault_type kind;
      v = '0;
      if (shadow_fill >= 2) begin
         judge_tag(shadow_win[0], shadow_win[1], b);
         shadow_win[0] = shadow_win[1];
         shadow_win[1] = b;
      end else begin
         shadow_win[shadow_fill] = b;
         shadow_fill++;
      end
      if (!last)
         return 1'b0;
      // flush the positions still waiting for lookahead
      if (shadow_fill >= 2) begin
         judge_tag(shadow_win[0], shadow_win[1], 8'h00);
         judge_tag(shadow_win[1], 8'h00, 8'h00);
      end else if (shadow_fill == 1) begin
         judge_tag(shadow_win[0], 8'h00, 8'h00);
      end
      kind = shadow_fault;
      if (kind == FAULT_NONE && shadow_depth != 0)
         kind = FAULT_OPEN;
      v.ok   = (kind == FAULT_NONE);
      v.kind = kind;
      shadow_depth  = 0;
      shadow_win[0] = 8'h00;
      shadow_win[1] = 8'h00;
      shadow_fill   = 0;
      shadow_fault  = FAULT_NONE;
      return 1'b1;
   endfunction

   task automatic send_word(input logic [7:0] b, input bit last, input bit typed,
                            input verdict_type want);
      verdict_type v;
      if (bytes_sent < BYTE_TARGET / 3) begin
         tx_idle_pct = 36;
         rx_idle_pct = 72;
      end else if (bytes_sent < 2 * BYTE_TARGET / 3) begin
         tx_idle_pct = 72;
         rx_idle_pct = 36;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= b;
      req_is_last <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
      if (line_verdict(b, last, v)) begin
         verdict_q.push_back(typed ? want : v);
         lines_done++;
      end
   endtask

   task automatic add_row(input logic [7:0] ch, input bit last, input bit typed,
                          input logic ok, input fault_type kind);
      row_type r;
      r.ch        = ch;
      r.last      = last;
      r.typed     = typed && last;
      r.want.ok   = ok;
      r.want.kind = kind;
      script.push_back(r);
   endtask

   task automatic add_text(input string s, input bit typed, input logic ok,
                           input fault_type kind);
      for (int i = 0; i < s.len(); i++)
         add_row(s[i], i == s.len() - 1, typed, ok, kind);
   endtask

   function automatic logic [7:0] random_tag();
      logic [7:0] t;
      do
         t = 8'($urandom_range(255));
      while (t == OPEN_MARK || t == CLOSE_MARK);
      return t;
   endfunction

   function automatic logic [7:0] random_filler();
      logic [7:0] t;
      do
         t = 8'($urandom_range(255));
      while (t == OPEN_MARK);
      return t;
   endfunction

   task automatic push_open(input logic [7:0] t);
      line_buf.push_back(OPEN_MARK);
      line_buf.push_back(t);
   endtask

   task automatic push_close(input logic [7:0] t);
      line_buf.push_back(OPEN_MARK);
      line_buf.push_back(CLOSE_MARK);
      line_buf.push_back(t);
   endtask

   task automatic compose_line();
      logic [7:0] open_tags [$];
      logic [7:0] t;
      int         mode;
      int         opens;
      int         pos;
      int         keep;
      line_buf.delete();
      mode = $urandom_range(99);
      if (mode < 75) begin
         if ($urandom_range(39) == 0) begin
            // deep nest around the stack limit
            repeat ($urandom_range(TAG_DEPTH - 2, TAG_DEPTH + 6)) begin
               t = random_tag();
               push_open(t);
               open_tags.push_back(t);
            end
         end else begin
            opens = $urandom_range(0, 5);
            while (opens > 0 || open_tags.size() > 0) begin
               if ($urandom_range(3) == 0)
                  line_buf.push_back(random_filler());
               if (opens > 0 && (open_tags.size() == 0 || $urandom_range(1) == 1)) begin
                  t = random_tag();
                  push_open(t);
                  open_tags.push_back(t);
                  opens--;
               end else begin
                  push_close(open_tags.pop_back());
               end
            end
         end
         while (open_tags.size() > 0)
            push_close(open_tags.pop_back());
         if (line_buf.size() == 0)
            line_buf.push_back(random_filler());
         if (mode >= 50) begin
            pos = $urandom_range(line_buf.size() - 1);
            case ($urandom_range(3))
               0: line_buf[pos] = line_buf[pos] ^ (8'h01 << $urandom_range(7));
               1: if (line_buf.size() > 1) line_buf.delete(pos);
               2: push_close(random_tag());
               default: begin
                  // cut the line short
                  keep = $urandom_range(1, line_buf.size());
                  while (line_buf.size() > keep)
                     void'(line_buf.pop_back());
               end
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(4))
               0: line_buf.push_back(OPEN_MARK);
               1: line_buf.push_back(CLOSE_MARK);
               2: line_buf.push_back($urandom_range(1) ? 8'hFF : 8'h00);
               default: line_buf.push_back(8'($urandom_range(255)));
            endcase
         end
      end
   endtask

   task automatic check_verdict();
      verdict_type want;
      if (verdict_q.size() == 0) begin
         report_fault($sformatf("verdict ok=%0d kind=%0d with no line pending",
                                rsp_line_valid, rsp_fault_kind));
         return;
      end
      want = verdict_q.pop_front();
      verdicts_seen++;
      if (want.kind <= FAULT_OVERFLOW)
         kind_seen[want.kind]++;
      if (rsp_line_valid !== want.ok)
         report_fault($sformatf("line_valid got %0d want %0d (verdict %0d)",
                                rsp_line_valid, want.ok, verdicts_seen));
      if (rsp_fault_kind !== want.kind)
         report_fault($sformatf("fault_kind got %0d want %0d (verdict %0d)",
                                rsp_fault_kind, want.kind, verdicts_seen));
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_verdict();
         if (!hold_done && bytes_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles, %0d verdicts pending",
                  idle_cycles, verdict_q.size());
         $display("[tag_nesting_checker] ERROR");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_char_in = 8'h00;
      req_is_last = 1'b0;
      shadow_win[0] = 8'h00;
      shadow_win[1] = 8'h00;

      // lone open mark pushes the empty tag and leaves it open
      add_text("<", 1'b1, 1'b0, FAULT_OPEN);
      add_text("</", 1'b1, 1'b0, FAULT_EMPTY);
      add_text("<a</a", 1'b1, 1'b1, FAULT_NONE);
      add_text("<a</b", 1'b1, 1'b0, FAULT_MISMATCH);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, FAULT_NONE);
      add_row(8'hFF, 1'b1, 1'b1, 1'b1, FAULT_NONE);
      add_text("<<", 1'b0, 1'b0, FAULT_NONE);
      add_text("<ab</a", 1'b0, 1'b0, FAULT_NONE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_word(script[i].ch, script[i].last, script[i].typed, script[i].want);

      while (bytes_sent < BYTE_TARGET || lines_done < LINE_TARGET) begin
         compose_line();
         foreach (line_buf[i])
            send_word(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d bytes in %0d lines, %0d verdicts compared", bytes_sent,
               lines_done, verdicts_seen);
      $display("verdicts by kind: clean %0d, mismatch %0d, empty close %0d, open %0d, overflow %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (fail_count == 0)
         $display("[tag_nesting_checker] OK");
      else
         $display("[tag_nesting_checker] ERROR");
      $finish;
   end

endmodule
